// ----- design/assert_macros.svh -----
// Assertion macros for the ZIP header stripper RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clk edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLKD(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- design/zlhs_pkg.sv -----
// Types and constants of the ZIP local header stripper.
// No dependencies; used by all modules and the testbench.
package zlhs_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_NOTZIP = 3'd2,
    ST_BADHDR = 3'd3,
    ST_EOF    = 3'd4,
    ST_MULTI  = 3'd5
  } status_t;

  localparam logic [31:0] LOCAL_SIG      = 32'h04034b50;
  localparam logic [31:0] CENTRAL_SIG    = 32'h02014b50;
  localparam logic [15:0] FLAG_MASK      = 16'h0041;
  localparam logic [15:0] VERSION_NEEDED = 16'd20;
  localparam logic [15:0] METHOD_DEFLATE = 16'd8;

  // Header byte index of the last byte of each field of interest, then the trailer length.
  localparam logic [4:0] POS_SIG_END     = 5'd3;
  localparam logic [4:0] POS_VERSION_END = 5'd5;
  localparam logic [4:0] POS_FLAGS_END   = 5'd7;
  localparam logic [4:0] POS_METHOD_END  = 5'd9;
  localparam logic [4:0] POS_CSIZE_END   = 5'd21;
  localparam logic [4:0] POS_NAME_END    = 5'd27;
  localparam logic [4:0] POS_EXTRA_END   = 5'd29;
  localparam logic [4:0] TRAILER_BYTES   = 5'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_t    status;
  } result_t;

endpackage

// ----- design/zlhs_stream_if.sv -----
// Valid/ready channels of the ZIP local header stripper.
// No dependencies; the status field is a plain logic [2:0], not the zlhs_pkg type.
interface zlhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;
  modport source(output valid, data_byte, end_of_input, input ready);
  modport sink(input valid, data_byte, end_of_input, output ready);
endinterface

interface zlhs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [2:0] status;
  modport source(output valid, payload_byte, payload_valid, status, input ready);
  modport sink(input valid, payload_byte, payload_valid, status, output ready);
endinterface

// ----- design/zlhs_in_stage.sv -----
// Input register of the ZIP local header stripper.
// Depends on zlhs_pkg and zlhs_in_if.
module zlhs_in_stage (
  input  logic                clk,
  input  logic                rst,
  zlhs_in_if.sink             in_ch,
  input  logic                advance,
  output logic                item_valid,
  output zlhs_pkg::in_item_t  item
);

  // Take a new word when empty or when the held one moves on this cycle.
  assign in_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.data_byte    <= in_ch.data_byte;
      item.end_of_input <= in_ch.end_of_input;
    end
  end

endmodule

// ----- design/zlhs_parser.sv -----
// Header parser state and per-word result logic of the ZIP stripper.
// Depends on zlhs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module zlhs_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  zlhs_pkg::in_item_t  item,
  output zlhs_pkg::result_t   res
);

  zlhs_pkg::phase_t  phase, phase_next;
  zlhs_pkg::status_t status, status_next;
  logic [4:0]  hpos, hpos_next;
  logic [31:0] acc, acc_next;
  logic [31:0] pay_rem, pay_rem_next;
  logic [15:0] name_len, name_len_next;
  logic [16:0] skip_rem, skip_rem_next;

  logic [31:0] acc_shift;
  logic [15:0] half;
  logic [16:0] skip_sum;
  logic [16:0] skip_dec;
  logic [31:0] pay_dec;
  logic [4:0]  hpos_inc;

  assign acc_shift = {item.data_byte, acc[31:8]};
  assign half      = acc_shift[31:16];
  assign skip_sum  = {1'b0, name_len} + {1'b0, half};
  assign skip_dec  = skip_rem - 17'd1;
  assign pay_dec   = pay_rem - 32'd1;
  assign hpos_inc  = hpos + 5'd1;

  always_comb begin
    phase_next        = phase;
    status_next       = status;
    hpos_next         = hpos;
    acc_next          = acc;
    pay_rem_next      = pay_rem;
    name_len_next     = name_len;
    skip_rem_next     = skip_rem;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;
    if (status == zlhs_pkg::ST_RUN) begin
      if (item.end_of_input) begin
        status_next = zlhs_pkg::ST_EOF;
      end else begin
        unique case (phase)
          zlhs_pkg::PH_HEADER: begin
            acc_next  = acc_shift;
            hpos_next = hpos_inc;
            case (hpos)
              zlhs_pkg::POS_SIG_END: begin
                if (acc_shift != zlhs_pkg::LOCAL_SIG) status_next = zlhs_pkg::ST_NOTZIP;
              end
              zlhs_pkg::POS_VERSION_END: begin
                if (half != zlhs_pkg::VERSION_NEEDED) status_next = zlhs_pkg::ST_BADHDR;
              end
              zlhs_pkg::POS_FLAGS_END: begin
                if ((half & zlhs_pkg::FLAG_MASK) != 16'd0) status_next = zlhs_pkg::ST_BADHDR;
              end
              zlhs_pkg::POS_METHOD_END: begin
                if (half != zlhs_pkg::METHOD_DEFLATE) status_next = zlhs_pkg::ST_BADHDR;
              end
              zlhs_pkg::POS_CSIZE_END: begin
                pay_rem_next = acc_shift;
              end
              zlhs_pkg::POS_NAME_END: begin
                name_len_next = half;
              end
              zlhs_pkg::POS_EXTRA_END: begin
                skip_rem_next = skip_sum;
                hpos_next     = 5'd0;
                acc_next      = 32'd0;
                if (skip_sum != 17'd0) phase_next = zlhs_pkg::PH_SKIP;
                else if (pay_rem != 32'd0) phase_next = zlhs_pkg::PH_PAYLOAD;
                else phase_next = zlhs_pkg::PH_TRAILER;
              end
              default: ;
            endcase
          end
          zlhs_pkg::PH_SKIP: begin
            skip_rem_next = skip_dec;
            if (skip_dec == 17'd0) begin
              phase_next = (pay_rem != 32'd0) ? zlhs_pkg::PH_PAYLOAD : zlhs_pkg::PH_TRAILER;
            end
          end
          zlhs_pkg::PH_PAYLOAD: begin
            res.payload_byte  = item.data_byte;
            res.payload_valid = 1'b1;
            pay_rem_next      = pay_dec;
            if (pay_dec == 32'd0) phase_next = zlhs_pkg::PH_TRAILER;
          end
          zlhs_pkg::PH_TRAILER: begin
            acc_next  = acc_shift;
            hpos_next = hpos_inc;
            if (hpos_inc >= zlhs_pkg::TRAILER_BYTES) begin
              status_next = (acc_shift == zlhs_pkg::CENTRAL_SIG) ?
                            zlhs_pkg::ST_DONE : zlhs_pkg::ST_MULTI;
            end
          end
        endcase
      end
    end
    res.status = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= zlhs_pkg::PH_HEADER;
      status   <= zlhs_pkg::ST_RUN;
      hpos     <= 5'd0;
      acc      <= 32'd0;
      pay_rem  <= 32'd0;
      name_len <= 16'd0;
      skip_rem <= 17'd0;
    end else if (step) begin
      phase    <= phase_next;
      status   <= status_next;
      hpos     <= hpos_next;
      acc      <= acc_next;
      pay_rem  <= pay_rem_next;
      name_len <= name_len_next;
      skip_rem <= skip_rem_next;
    end
  end

  // A final status never changes again.
  `ASSERT_CLKD(a_status_sticky, clk, rst,
    (status != zlhs_pkg::ST_RUN) |=> (status == $past(status)))
  // Skip and payload phases always have bytes left to consume.
  `ASSERT_CLKD(a_skip_nonzero, clk, rst,
    (status == zlhs_pkg::ST_RUN && phase == zlhs_pkg::PH_SKIP) |-> (skip_rem != 17'd0))
  `ASSERT_CLKD(a_pay_nonzero, clk, rst,
    (status == zlhs_pkg::ST_RUN && phase == zlhs_pkg::PH_PAYLOAD) |-> (pay_rem != 32'd0))
  // Payload bytes come out only in the payload phase while running.
  `ASSERT_CLKD(a_pass_phase, clk, rst,
    res.payload_valid |-> (phase == zlhs_pkg::PH_PAYLOAD && status == zlhs_pkg::ST_RUN))

endmodule

// ----- design/zlhs_out_stage.sv -----
// Result register of the ZIP local header stripper.
// Depends on zlhs_pkg and zlhs_out_if.
module zlhs_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  zlhs_pkg::result_t  res,
  output logic               free,
  zlhs_out_if.source         out_ch
);

  zlhs_pkg::result_t held;

  assign free                 = !out_ch.valid || out_ch.ready;
  assign out_ch.payload_byte  = held.payload_byte;
  assign out_ch.payload_valid = held.payload_valid;
  assign out_ch.status        = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (free) begin
      out_ch.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ----- design/zip_local_header_stripper_unit.sv -----
// ZIP local header stripper: takes one byte of the archive stream per cycle while the
// output side is ready, and returns one result word per input word, through the input
// register and then the result register. The sustained rate is one word per cycle; the
// parser updates in the same step that moves a word from the input register into the result
// register, and a stalled output holds the pipeline until its word is taken.
module zip_local_header_stripper_unit (
  input  logic        clk,
  input  logic        rst,
  zlhs_in_if.sink     in_ch,
  zlhs_out_if.source  out_ch
);

  logic               item_valid;
  logic               free;
  logic               step;
  zlhs_pkg::in_item_t item;
  zlhs_pkg::result_t  res;

  // Advance the held input word into the parser when the result slot frees.
  assign step = item_valid && free;

  zlhs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (free),
    .item_valid (item_valid),
    .item       (item)
  );

  zlhs_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res)
  );

  zlhs_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule

// ----- bench/zip_local_header_stripper_unit_test.sv -----
// Testbench for zip_local_header_stripper_unit: builds one archive stream per run,
// feeds it word by word and checks every result word against a local predictor.
// Depends on zlhs_pkg and the zlhs_in_if / zlhs_out_if channel interfaces.
module zip_local_header_stripper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD     = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_WORDS  = 850;

  typedef enum int {
    ARC_GOOD,
    ARC_BAD_SIG,
    ARC_BAD_FIELD,
    ARC_BAD_TRAILER,
    ARC_CUT_SHORT
  } archive_kind_t;

  typedef enum int {
    FLD_VERSION,
    FLD_FLAGS,
    FLD_METHOD
  } header_field_t;

  // Tracks the stripper state and the result words still owed by the block.
  class strip_scoreboard;
    zlhs_pkg::phase_t  phase;
    logic [4:0]        hdr_pos;
    logic [31:0]       shift_word;
    logic [31:0]       payload_left;
    logic [15:0]       name_len;
    logic [16:0]       skip_left;
    zlhs_pkg::status_t status;
    zlhs_pkg::result_t awaited[$];
    int                errors;

    function new();
      phase        = zlhs_pkg::PH_HEADER;
      hdr_pos      = '0;
      shift_word   = '0;
      payload_left = '0;
      name_len     = '0;
      skip_left    = '0;
      status       = zlhs_pkg::ST_RUN;
      errors       = 0;
    endfunction

    function void note_word(logic [7:0] b, logic eoi);
      zlhs_pkg::result_t res;
      logic [4:0]        pos;
      logic [15:0]       half;
      res.payload_byte  = 8'h00;
      res.payload_valid = 1'b0;
      if (status == zlhs_pkg::ST_RUN) begin
        if (eoi) begin
          status = zlhs_pkg::ST_EOF;
        end else begin
          case (phase)
            zlhs_pkg::PH_HEADER: begin
              pos        = hdr_pos;
              shift_word = {b, shift_word[31:8]};
              half       = shift_word[31:16];
              hdr_pos    = pos + 5'd1;
              case (pos)
                zlhs_pkg::POS_SIG_END: begin
                  if (shift_word != zlhs_pkg::LOCAL_SIG) status = zlhs_pkg::ST_NOTZIP;
                end
                zlhs_pkg::POS_VERSION_END: begin
                  if (half != zlhs_pkg::VERSION_NEEDED) status = zlhs_pkg::ST_BADHDR;
                end
                zlhs_pkg::POS_FLAGS_END: begin
                  if ((half & zlhs_pkg::FLAG_MASK) != 16'd0) status = zlhs_pkg::ST_BADHDR;
                end
                zlhs_pkg::POS_METHOD_END: begin
                  if (half != zlhs_pkg::METHOD_DEFLATE) status = zlhs_pkg::ST_BADHDR;
                end
                zlhs_pkg::POS_CSIZE_END: payload_left = shift_word;
                zlhs_pkg::POS_NAME_END:  name_len = half;
                zlhs_pkg::POS_EXTRA_END: begin
                  skip_left  = {1'b0, name_len} + {1'b0, half};
                  hdr_pos    = '0;
                  shift_word = '0;
                  if (skip_left != 17'd0) phase = zlhs_pkg::PH_SKIP;
                  else if (payload_left != 32'd0) phase = zlhs_pkg::PH_PAYLOAD;
                  else phase = zlhs_pkg::PH_TRAILER;
                end
                default: ;
              endcase
            end
            zlhs_pkg::PH_SKIP: begin
              skip_left = skip_left - 17'd1;
              if (skip_left == 17'd0) begin
                if (payload_left != 32'd0) phase = zlhs_pkg::PH_PAYLOAD;
                else phase = zlhs_pkg::PH_TRAILER;
              end
            end
            zlhs_pkg::PH_PAYLOAD: begin
              res.payload_byte  = b;
              res.payload_valid = 1'b1;
              payload_left      = payload_left - 32'd1;
              if (payload_left == 32'd0) phase = zlhs_pkg::PH_TRAILER;
            end
            default: begin
              // central directory signature follows the payload
              shift_word = {b, shift_word[31:8]};
              hdr_pos    = hdr_pos + 5'd1;
              if (hdr_pos >= zlhs_pkg::TRAILER_BYTES) begin
                if (shift_word == zlhs_pkg::CENTRAL_SIG) status = zlhs_pkg::ST_DONE;
                else status = zlhs_pkg::ST_MULTI;
              end
            end
          endcase
        end
      end
      res.status = status;
      awaited.push_back(res);
    endfunction

    function void check_result(logic [7:0] pb, logic pv, logic [2:0] st);
      zlhs_pkg::result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word: payload_byte %h payload_valid %b status %0d",
                 $time, pb, pv, st);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pb !== want.payload_byte) begin
        $display("%0t: payload_byte expected %h actual %h", $time, want.payload_byte, pb);
        errors++;
      end
      if (pv !== want.payload_valid) begin
        $display("%0t: payload_valid expected %b actual %b", $time, want.payload_valid, pv);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  zlhs_in_if  in_ch ();
  zlhs_out_if out_ch ();

  zip_local_header_stripper_unit dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  strip_scoreboard sb = new();

  zlhs_pkg::in_item_t arc_words[$];
  int                 cut_len;
  bit                 src_quiet;
  bit                 sink_quiet;
  bit                 long_hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] b;
    do b = 8'($urandom()); while (b == v);
    return b;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    zlhs_pkg::in_item_t w;
    if (arc_words.size() < cut_len) begin
      w.data_byte    = b;
      w.end_of_input = 1'b0;
      arc_words.push_back(w);
    end
  endfunction

  function automatic void add_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endfunction

  // One archive per run: the block only ever parses the first one after reset.
  function automatic void build_archive();
    archive_kind_t      kind;
    header_field_t      bad_field;
    zlhs_pkg::in_item_t w;
    logic [31:0]        sig, trailer, csize;
    logic [15:0]        version, flags, method, name_len, extra_len;
    int                 n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: kind = ARC_GOOD;
      5:             kind = ARC_BAD_SIG;
      6:             kind = ARC_BAD_FIELD;
      7:             kind = ARC_BAD_TRAILER;
      default:       kind = ARC_CUT_SHORT;
    endcase
    sig       = zlhs_pkg::LOCAL_SIG;
    trailer   = zlhs_pkg::CENTRAL_SIG;
    version   = zlhs_pkg::VERSION_NEEDED;
    method    = zlhs_pkg::METHOD_DEFLATE;
    flags     = 16'($urandom_range(0, 65535)) & ~zlhs_pkg::FLAG_MASK;
    name_len  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
    extra_len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    csize     = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(700, 800));
    cut_len   = 32'h7fff_ffff;
    case (kind)
      ARC_BAD_SIG: sig = zlhs_pkg::LOCAL_SIG ^ (32'd1 << $urandom_range(0, 31));
      ARC_BAD_FIELD: begin
        bad_field = header_field_t'($urandom_range(0, 2));
        case (bad_field)
          FLD_VERSION: begin
            if ($urandom_range(0, 1) == 1)
              version = {8'h00, other_than(zlhs_pkg::VERSION_NEEDED[7:0])};
            else
              version = {8'($urandom_range(1, 255)), zlhs_pkg::VERSION_NEEDED[7:0]};
          end
          FLD_FLAGS: begin
            // encrypted, strong encryption, or both
            case ($urandom_range(0, 2))
              0:       flags = flags | 16'h0001;
              1:       flags = flags | 16'h0040;
              default: flags = flags | zlhs_pkg::FLAG_MASK;
            endcase
          end
          default: begin
            if ($urandom_range(0, 1) == 1)
              method = {8'h00, other_than(zlhs_pkg::METHOD_DEFLATE[7:0])};
            else
              method = {8'($urandom_range(1, 255)), zlhs_pkg::METHOD_DEFLATE[7:0]};
          end
        endcase
      end
      ARC_BAD_TRAILER: begin
        // a second local header means a second entry; otherwise a corrupted central signature
        if ($urandom_range(0, 1) == 1) trailer = zlhs_pkg::LOCAL_SIG;
        else trailer = zlhs_pkg::CENTRAL_SIG ^ (32'd1 << $urandom_range(0, 31));
      end
      ARC_CUT_SHORT: begin
        cut_len = $urandom_range(0, 860);
        if ($urandom_range(0, 1) == 1) csize = $urandom();
        if ($urandom_range(0, 1) == 1) name_len = 16'($urandom());
        if ($urandom_range(0, 1) == 1) extra_len = 16'($urandom());
      end
      default: ;
    endcase

    arc_words.delete();
    add_le(sig, 4);
    add_le({16'd0, version}, 2);
    add_le({16'd0, flags}, 2);
    add_le({16'd0, method}, 2);
    add_le($urandom(), 4);  // time and date
    add_le($urandom(), 4);  // crc
    add_le(csize, 4);
    add_le($urandom(), 4);  // uncompressed size
    add_le({16'd0, name_len}, 2);
    add_le({16'd0, extra_len}, 2);
    for (int i = 0; i < name_len + extra_len && arc_words.size() < cut_len; i++)
      add_byte(8'($urandom()));
    for (longint i = 0; i < csize && arc_words.size() < cut_len; i++)
      add_byte(8'($urandom()));
    add_le(trailer, 4);

    if (kind == ARC_CUT_SHORT) begin
      w.data_byte    = 8'($urandom());
      w.end_of_input = 1'b1;
      arc_words.push_back(w);
    end
    // trailing words after the verdict must leave the status alone; pad short streams
    if (arc_words.size() < TARGET_WORDS - 20) n = TARGET_WORDS - arc_words.size();
    else n = $urandom_range(4, 20);
    for (int i = 0; i <= n; i++) begin
      w.data_byte    = 8'($urandom());
      w.end_of_input = (i == n) || ($urandom_range(0, 4) == 0);
      arc_words.push_back(w);
    end
  endfunction

  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    gap = gap_len(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the input until every owed result word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.data_byte, in_ch.end_of_input);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.payload_byte, out_ch.payload_valid, out_ch.status);
    end
  end

  initial begin
    int sink_hold;
    int sink_cycles;
    out_ch.ready <= 1'b0;
    sink_hold   = 0;
    sink_cycles = 0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if (sink_cycles % 64 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      if (sink_hold == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          sink_hold     = LONG_HOLD;
        end else begin
          sink_hold = gap_len(sink_quiet);
        end
      end
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    zlhs_pkg::in_item_t w;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    build_archive();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < arc_words.size(); i++) begin
      if (i % 64 == 0) src_quiet = ($urandom_range(0, 3) == 0);
      if (i == arc_words.size() / 3) drain_results();
      // stall the output while words keep coming so the block backs up
      if (i == arc_words.size() / 2) long_hold_req = 1'b1;
      w = arc_words[i];
      send_word(w.data_byte, w.end_of_input);
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("zip_local_header_stripper_unit_test: clean");
    end else begin
      $display("zip_local_header_stripper_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("zip_local_header_stripper_unit_test: errors");
    $finish;
  end

endmodule
